FILE: rtl/core/hss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hss_pkg;

  // Number of positions the phase steps through.
  localparam int unsigned PHASES = 8;

  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned VCOUNT_W  = 9;
  localparam int unsigned COILS_W   = 4;
  localparam int unsigned TABLE_W   = 32;
  localparam int unsigned CFG_W     = 32;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [1:0] CMD_HOLD  = 2'd0;
  localparam logic [1:0] CMD_CW    = 2'd1;
  localparam logic [1:0] CMD_CCW   = 2'd2;
  localparam logic [1:0] CMD_VIBE  = 2'd3;

  localparam logic REG_STEP_INTERVAL = 1'b0;
  localparam logic REG_PHASE_TABLE   = 1'b1;

  localparam logic [ELAPSED_W-1:0] STEP_INTERVAL_RST = 20'd2000;
  localparam logic [TABLE_W-1:0]   PHASE_TABLE_RST   = 32'd2562376465;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [PHASE_W-1:0]   phase;
    logic [VCOUNT_W-1:0]  vcount;
    logic [COILS_W-1:0]   coil_latch;
  } hss_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] forward_steps;
    logic [7:0] reverse_steps;
  } hss_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/hss_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] forward_steps;
  logic [7:0] reverse_steps;

  modport source (output valid, cmd, forward_steps, reverse_steps, input ready);
  modport sink   (input valid, cmd, forward_steps, reverse_steps, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hss_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coils;
  logic       stepped;

  modport source (output valid, coils, stepped, input ready);
  modport sink   (input valid, coils, stepped, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hss_step.sv
`timescale 1ns / 1ps
`default_nettype none
module hss_step (
  input  hss_pkg::hss_state_t                 st,
  input  hss_pkg::hss_item_t                  item,
  input  logic [hss_pkg::ELAPSED_W-1:0]       step_interval,
  input  logic [hss_pkg::TABLE_W-1:0]         phase_table,
  output hss_pkg::hss_state_t                 nxt,
  output logic                                stepped
);

  localparam logic [hss_pkg::PHASE_W-1:0] PHASE_END = hss_pkg::PHASE_W'(hss_pkg::PHASES);
  localparam logic [hss_pkg::PHASE_W-1:0] PHASE_TOP = hss_pkg::PHASE_W'(hss_pkg::PHASES - 1);

  function automatic logic [hss_pkg::COILS_W-1:0] pattern_of(
    input logic [hss_pkg::TABLE_W-1:0] tbl,
    input logic [hss_pkg::PHASE_W-1:0] idx
  );
    pattern_of = tbl[{idx[2:0], 2'b00} +: hss_pkg::COILS_W];
  endfunction

  function automatic logic [hss_pkg::PHASE_W-1:0] phase_back(
    input logic [hss_pkg::PHASE_W-1:0] p
  );
    if (p == '0 || p > PHASE_END) phase_back = PHASE_TOP;
    else                          phase_back = p - 1'b1;
  endfunction

  function automatic logic [hss_pkg::PHASE_W-1:0] phase_fwd(
    input logic [hss_pkg::PHASE_W-1:0] p
  );
    if (p >= PHASE_TOP) phase_fwd = '0;
    else                phase_fwd = p + 1'b1;
  endfunction

  logic [hss_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic [hss_pkg::PHASE_W-1:0]   cw_phase;
  logic [hss_pkg::PHASE_W-1:0]   new_phase;
  logic [hss_pkg::VCOUNT_W-1:0]  cnt_inc;
  logic [hss_pkg::VCOUNT_W-1:0]  cycle_len;

  assign elapsed_inc = (st.elapsed == hss_pkg::ELAPSED_MAX) ? st.elapsed
                                                            : st.elapsed + 1'b1;
  assign stepped   = (item.cmd != hss_pkg::CMD_HOLD) && (elapsed_inc > step_interval);
  assign cw_phase  = (st.phase >= PHASE_END) ? '0 : st.phase;
  assign cnt_inc   = st.vcount + 1'b1;
  assign cycle_len = {1'b0, item.forward_steps} + {1'b0, item.reverse_steps};

  always_comb begin
    nxt = st;
    nxt.elapsed = elapsed_inc;
    new_phase = st.phase;
    if (stepped) begin
      nxt.elapsed = '0;
      case (item.cmd)
        hss_pkg::CMD_CW: begin
          // Clockwise shows the current pattern, then advances.
          nxt.coil_latch = pattern_of(phase_table, cw_phase);
          nxt.phase = cw_phase + 1'b1;
        end
        hss_pkg::CMD_CCW: begin
          new_phase = phase_back(st.phase);
          nxt.phase = new_phase;
          nxt.coil_latch = pattern_of(phase_table, new_phase);
        end
        hss_pkg::CMD_VIBE: begin
          if (st.vcount < {1'b0, item.forward_steps}) begin
            new_phase = phase_fwd(st.phase);
            nxt.vcount = cnt_inc;
          end else begin
            new_phase = phase_back(st.phase);
            nxt.vcount = (cnt_inc == cycle_len) ? '0 : cnt_inc;
          end
          nxt.phase = new_phase;
          nxt.coil_latch = pattern_of(phase_table, new_phase);
        end
        default: begin
          nxt.elapsed = elapsed_inc;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/half_step_stepper_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// Half-step stepper sequencer.
// Each transaction on in_ch is one microsecond tick with a command (hold,
// clockwise, anticlockwise, vibrate) and the vibrate forward/reverse step
// counts. Every tick yields exactly one transaction on out_ch carrying the
// latched coil pattern and a flag that is set when a step was taken.
// An accepted tick sits in an input register, where the step logic compares
// the elapsed counter with the interval, picks the next phase and selects
// its pattern; the result register is loaded from it once out_ch is free.
// One tick is accepted every cycle while out_ch keeps taking results; the
// single path through the step logic and state registers sets that rate.
// When out_ch stalls, the result register holds, the input register fills,
// and in_ch.ready then drops until the result is taken.
// Configuration (cfg_we, cfg_index, cfg_data) writes step_interval (index 0)
// or phase_table (index 1); the user must use it only while no tick is in
// flight, as the block itself does not enforce this.
// Reset clears the counter, phase, vibrate count and coil latch, empties
// both registers and restores the default interval and phase table.
module half_step_stepper_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  hss_in_if.sink                    in_ch,
  hss_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [hss_pkg::CFG_W-1:0] cfg_data
);

  logic [hss_pkg::ELAPSED_W-1:0] step_interval;
  logic [hss_pkg::TABLE_W-1:0]   phase_table;

  hss_pkg::hss_state_t st;
  hss_pkg::hss_state_t st_next;
  hss_pkg::hss_item_t  item;
  logic                item_valid;
  logic                step_hit;

  logic out_free;
  logic item_fire;
  logic in_fire;

  assign out_free  = !out_ch.valid || out_ch.ready;
  assign item_fire = item_valid && out_free;
  assign in_ch.ready = !item_valid || out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= hss_pkg::STEP_INTERVAL_RST;
      phase_table   <= hss_pkg::PHASE_TABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hss_pkg::REG_STEP_INTERVAL: step_interval <= cfg_data[hss_pkg::ELAPSED_W-1:0];
        hss_pkg::REG_PHASE_TABLE:   phase_table   <= cfg_data[hss_pkg::TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item.cmd           <= in_ch.cmd;
      item.forward_steps <= in_ch.forward_steps;
      item.reverse_steps <= in_ch.reverse_steps;
    end
  end

  hss_step u_step (
    .st            (st),
    .item          (item),
    .step_interval (step_interval),
    .phase_table   (phase_table),
    .nxt           (st_next),
    .stepped       (step_hit)
  );

  // State advances only when the tick moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (item_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_free) begin
      out_ch.valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      out_ch.coils   <= st_next.coil_latch;
      out_ch.stepped <= step_hit;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.phase <= hss_pkg::PHASE_W'(hss_pkg::PHASES))
    else $error("phase left its range");

  a_step_clears: assert property (@(posedge clk) disable iff (rst)
    item_fire && step_hit |=> st.elapsed == '0 && out_ch.stepped)
    else $error("step did not clear the elapsed counter");

  a_hold_no_step: assert property (@(posedge clk) disable iff (rst)
    item_fire && item.cmd == hss_pkg::CMD_HOLD |=> !out_ch.stepped && $stable(st.coil_latch))
    else $error("hold tick changed the coils");

endmodule
`default_nettype wire

FILE: tb/tb_half_step_stepper_sequencer.sv
`timescale 1ns / 1ps
module tb_half_step_stepper_sequencer;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 40;

  typedef enum int {RX_FULL, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [hss_pkg::COILS_W-1:0] coils;
    logic                        stepped;
  } coil_result_t;

  // Tracks the sequencer state and holds the coil patterns still owed by the block.
  class coil_scoreboard;
    logic [hss_pkg::ELAPSED_W-1:0] interval;
    logic [hss_pkg::TABLE_W-1:0]   pattern_word;
    logic [hss_pkg::ELAPSED_W-1:0] elapsed;
    logic [hss_pkg::PHASE_W-1:0]   phase;
    logic [hss_pkg::VCOUNT_W-1:0]  vcount;
    logic [hss_pkg::COILS_W-1:0]   latch;
    coil_result_t                  pending_coils[$];
    int                            errors;
    int                            n_results;

    function void reset_state();
      interval     = hss_pkg::STEP_INTERVAL_RST;
      pattern_word = hss_pkg::PHASE_TABLE_RST;
      elapsed      = '0;
      phase        = '0;
      vcount       = '0;
      latch        = '0;
      pending_coils.delete();
      errors       = 0;
      n_results    = 0;
    endfunction

    function void set_reg(logic idx, logic [hss_pkg::CFG_W-1:0] data);
      if (idx == hss_pkg::REG_STEP_INTERVAL) interval = data[hss_pkg::ELAPSED_W-1:0];
      else pattern_word = data[hss_pkg::TABLE_W-1:0];
    endfunction

    function logic [hss_pkg::COILS_W-1:0] pattern(logic [hss_pkg::PHASE_W-1:0] idx);
      return pattern_word[{idx[2:0], 2'b00} +: hss_pkg::COILS_W];
    endfunction

    function logic [hss_pkg::PHASE_W-1:0] phase_back(logic [hss_pkg::PHASE_W-1:0] p);
      if (p == 0 || p > hss_pkg::PHASES) return hss_pkg::PHASE_W'(hss_pkg::PHASES - 1);
      return p - 1'b1;
    endfunction

    function logic [hss_pkg::PHASE_W-1:0] phase_fwd(logic [hss_pkg::PHASE_W-1:0] p);
      if (p >= hss_pkg::PHASES - 1) return '0;
      return p + 1'b1;
    endfunction

    // Advances the sequencer by one tick and queues the coil pattern it shows.
    function void note_tick(hss_pkg::hss_item_t it);
      coil_result_t res;
      res.stepped = 1'b0;
      if (elapsed != hss_pkg::ELAPSED_MAX) elapsed = elapsed + 1'b1;
      if (it.cmd != hss_pkg::CMD_HOLD && elapsed > interval) begin
        elapsed     = '0;
        res.stepped = 1'b1;
        case (it.cmd)
          hss_pkg::CMD_CW: begin
            if (phase >= hss_pkg::PHASES) phase = '0;
            latch = pattern(phase);
            phase = phase + 1'b1;
          end
          hss_pkg::CMD_CCW: begin
            phase = phase_back(phase);
            latch = pattern(phase);
          end
          default: begin
            if (vcount < {1'b0, it.forward_steps}) begin
              phase  = phase_fwd(phase);
              vcount = vcount + 1'b1;
              latch  = pattern(phase);
            end else begin
              phase  = phase_back(phase);
              vcount = vcount + 1'b1;
              latch  = pattern(phase);
              if (int'(vcount) == int'(it.forward_steps) + int'(it.reverse_steps))
                vcount = '0;
            end
          end
        endcase
      end
      res.coils = latch;
      pending_coils.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [hss_pkg::COILS_W-1:0] coils, logic stepped);
      coil_result_t want;
      n_results++;
      if (pending_coils.size() == 0) begin
        report($sformatf("result %0d arrived with no tick pending", n_results));
      end else begin
        want = pending_coils.pop_front();
        if (coils !== want.coils)
          report($sformatf("result %0d coils %h, expected %h", n_results, coils, want.coils));
        if (stepped !== want.stepped)
          report($sformatf("result %0d stepped %b, expected %b", n_results, stepped,
                           want.stepped));
      end
    endtask

    function int pending();
      return pending_coils.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [hss_pkg::CFG_W-1:0] cfg_data;

  hss_in_if  in_ch ();
  hss_out_if out_ch ();

  half_step_stepper_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  coil_scoreboard sb;
  bit             hold_off_req;
  int             burst_left;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic send_tick(input hss_pkg::hss_item_t it);
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= it.cmd;
    in_ch.forward_steps <= it.forward_steps;
    in_ch.reverse_steps <= it.reverse_steps;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(it);
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  task automatic offer(input hss_pkg::hss_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 2) != 0) idle_in($urandom_range(1, 8));
    end
    burst_left--;
    send_tick(it);
  endtask

  // Stops offering and waits until every owed result has been taken.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [hss_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic directed_ticks();
    hss_pkg::hss_item_t it;
    it = '0;
    it.cmd = hss_pkg::CMD_HOLD;
    repeat (2) send_tick(it);
    // Eight clockwise steps leave the phase resting one past the last entry.
    it.cmd = hss_pkg::CMD_CW;
    repeat (8) send_tick(it);
    it.cmd = hss_pkg::CMD_CCW;
    send_tick(it);
    it.cmd = hss_pkg::CMD_CW;
    send_tick(it);
    it.cmd           = hss_pkg::CMD_VIBE;
    it.forward_steps = 8'd1;
    it.reverse_steps = 8'd0;
    send_tick(it);
    // Backward from zero wraps to the last entry.
    it.cmd = hss_pkg::CMD_CCW;
    repeat (2) send_tick(it);
    it.cmd           = hss_pkg::CMD_VIBE;
    it.forward_steps = 8'hff;
    it.reverse_steps = 8'hff;
    repeat (2) send_tick(it);
    it.forward_steps = 8'd0;
    it.reverse_steps = 8'd0;
    send_tick(it);
    it.cmd = hss_pkg::CMD_HOLD;
    send_tick(it);
  endtask

  task automatic run_phase(input int n_items, input bit long_hold, input bit mid_drain);
    hss_pkg::hss_item_t it;
    logic [1:0]         cmd_pick [4];
    int                 sent;
    int                 run_len;
    bit                 wide;
    cmd_pick = '{hss_pkg::CMD_CW, hss_pkg::CMD_CCW, hss_pkg::CMD_VIBE, hss_pkg::CMD_HOLD};
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        // A steady command with fixed vibrate counts, as a motor would see it.
        wide             = ($urandom_range(0, 3) == 0);
        it.cmd           = cmd_pick[$urandom_range(0, 3)];
        it.forward_steps = wide ? 8'($urandom) : 8'($urandom_range(0, 6));
        it.reverse_steps = wide ? 8'($urandom) : 8'($urandom_range(0, 6));
        run_len          = $urandom_range(8, 80);
        repeat (run_len) begin
          offer(it);
          sent++;
        end
      end else begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) begin
          it.cmd           = 2'($urandom);
          it.forward_steps = 8'($urandom);
          it.reverse_steps = 8'($urandom);
          offer(it);
          sent++;
        end
      end
      if (long_hold && sent >= n_items / 3) begin
        hold_off_req = 1'b1;
        long_hold    = 1'b0;
      end
      if (mid_drain && sent >= n_items / 2) begin
        drain();
        mid_drain = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.coils, out_ch.stepped);
  end

  // Receiver: switches between always ready, random stalls and a repeating
  // stall pattern, and honors a long hold-off when one is requested.
  initial begin : rx_proc
    rx_mode_t    mode;
    int          mode_left;
    int          pct;
    logic [15:0] pat;
    int          k;
    int          hold_left;
    out_ch.ready = 1'b0;
    mode         = RX_FULL;
    mode_left    = 0;
    pct          = 50;
    pat          = '1;
    k            = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(32, 256);
        pct       = $urandom_range(20, 90);
        pat       = 16'($urandom);
      end
      mode_left--;
      k++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_FULL:   out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 99) < pct);
          default:   out_ch.ready <= pat[k % 16];
        endcase
      end
    end
  end

  initial begin
    #5000000;
    $display("** half_step_stepper_sequencer: FAILED **");
    $finish;
  end

  initial begin
    logic [hss_pkg::ELAPSED_W-1:0] intervals [10];
    logic [hss_pkg::TABLE_W-1:0]   tbl;
    int                            n;
    sb = new();
    sb.reset_state();
    intervals           = '{20'd0, 20'd1, 20'd4, 20'd1000000, 20'd2, 20'd0, 20'd7, 20'd3,
                            20'd1, 20'd0};
    hold_off_req        = 1'b0;
    burst_left          = 0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = hss_pkg::REG_STEP_INTERVAL;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = hss_pkg::CMD_HOLD;
    in_ch.forward_steps = '0;
    in_ch.reverse_steps = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(hss_pkg::REG_STEP_INTERVAL, '0);
    directed_ticks();

    for (int p = 0; p < 10; p++) begin
      drain();
      case (p % 4)
        0:       tbl = '0;
        1:       tbl = '1;
        2:       tbl = $urandom;
        default: tbl = hss_pkg::PHASE_TABLE_RST;
      endcase
      write_reg(hss_pkg::REG_STEP_INTERVAL,
                hss_pkg::CFG_W'(p == 7 ? $urandom_range(0, 30) : intervals[p]));
      write_reg(hss_pkg::REG_PHASE_TABLE, tbl);
      // The largest interval never steps within a phase, so keep that one short.
      n = (intervals[p] == 20'd1000000) ? 40 : 180;
      run_phase(n, p == 5, p == 6);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still owed at end of run");
    if (sb.errors == 0) begin
      $display("** half_step_stepper_sequencer: PASSED **");
    end else begin
      $display("** half_step_stepper_sequencer: FAILED **");
    end
    $finish;
  end
endmodule
